// ===== hw/rtl/gtr_pkg.sv =====
// ----------------------------------------------------------------------------
// gtr_pkg: shared constants for the glyph text rasterizer
// Holds the 5x7 column font, the glyph geometry and the pen limits.
// ----------------------------------------------------------------------------
package gtr_pkg;

  localparam logic [2:0] GLYPH_COLS = 3'd5;
  localparam logic [2:0] GLYPH_ROWS = 3'd7;
  localparam logic [2:0] LAST_COL   = 3'd4;
  localparam logic [2:0] LAST_ROW   = 3'd6;

  localparam logic signed [17:0] PEN_ADVANCE = 18'sd7;
  localparam logic signed [17:0] PEN_X_MAX   = 18'sd65535;

  localparam logic [7:0] CODE_DIGIT_LO = 8'h30;
  localparam logic [7:0] CODE_DIGIT_HI = 8'h39;
  localparam logic [7:0] CODE_UPPER_LO = 8'h41;
  localparam logic [7:0] CODE_UPPER_HI = 8'h5a;
  localparam logic [7:0] CODE_LOWER_LO = 8'h61;
  localparam logic [7:0] CODE_LOWER_HI = 8'h7a;
  localparam logic [7:0] CASE_FOLD     = 8'h20;
  localparam logic [7:0] CODE_DASH     = 8'h2d;
  localparam logic [7:0] CODE_DOT      = 8'h2e;
  localparam logic [2:0] MARK_COL      = 3'd2;
  localparam logic [6:0] DASH_BITS     = 7'h08;
  localparam logic [6:0] DOT_BITS      = 7'h60;

  // seven bits per column, bit n is row n
  localparam logic [6:0] DIGIT_FONT [0:9][0:4] = '{
    '{7'h3e, 7'h51, 7'h49, 7'h45, 7'h3e}, '{7'h00, 7'h42, 7'h7f, 7'h40, 7'h00},
    '{7'h62, 7'h51, 7'h49, 7'h49, 7'h46}, '{7'h22, 7'h49, 7'h49, 7'h49, 7'h36},
    '{7'h18, 7'h14, 7'h12, 7'h7f, 7'h10}, '{7'h2f, 7'h49, 7'h49, 7'h49, 7'h31},
    '{7'h3e, 7'h49, 7'h49, 7'h49, 7'h32}, '{7'h01, 7'h71, 7'h09, 7'h05, 7'h03},
    '{7'h36, 7'h49, 7'h49, 7'h49, 7'h36}, '{7'h26, 7'h49, 7'h49, 7'h49, 7'h3e}
  };

  localparam logic [6:0] ALPHA_FONT [0:25][0:4] = '{
    '{7'h7e, 7'h11, 7'h11, 7'h11, 7'h7e}, '{7'h7f, 7'h49, 7'h49, 7'h49, 7'h36},
    '{7'h3e, 7'h41, 7'h41, 7'h41, 7'h22}, '{7'h7f, 7'h41, 7'h41, 7'h22, 7'h1c},
    '{7'h7f, 7'h49, 7'h49, 7'h49, 7'h41}, '{7'h7f, 7'h09, 7'h09, 7'h09, 7'h01},
    '{7'h3e, 7'h41, 7'h49, 7'h49, 7'h7a}, '{7'h7f, 7'h08, 7'h08, 7'h08, 7'h7f},
    '{7'h00, 7'h41, 7'h7f, 7'h41, 7'h00}, '{7'h20, 7'h40, 7'h41, 7'h3f, 7'h01},
    '{7'h7f, 7'h08, 7'h14, 7'h22, 7'h41}, '{7'h7f, 7'h40, 7'h40, 7'h40, 7'h40},
    '{7'h7f, 7'h02, 7'h0c, 7'h02, 7'h7f}, '{7'h7f, 7'h04, 7'h08, 7'h10, 7'h7f},
    '{7'h3e, 7'h41, 7'h41, 7'h41, 7'h3e}, '{7'h7f, 7'h09, 7'h09, 7'h09, 7'h06},
    '{7'h3e, 7'h41, 7'h51, 7'h21, 7'h5e}, '{7'h7f, 7'h09, 7'h19, 7'h29, 7'h46},
    '{7'h46, 7'h49, 7'h49, 7'h49, 7'h31}, '{7'h01, 7'h01, 7'h7f, 7'h01, 7'h01},
    '{7'h3f, 7'h40, 7'h40, 7'h40, 7'h3f}, '{7'h1f, 7'h20, 7'h40, 7'h20, 7'h1f},
    '{7'h3f, 7'h40, 7'h38, 7'h40, 7'h3f}, '{7'h63, 7'h14, 7'h08, 7'h14, 7'h63},
    '{7'h07, 7'h08, 7'h70, 7'h08, 7'h07}, '{7'h61, 7'h51, 7'h49, 7'h45, 7'h43}
  };

  // font column lookup, blank for codes outside the font
  function automatic logic [6:0] font_column(input logic [7:0] code, input logic [2:0] col);
    logic [7:0] folded;
    logic [7:0] d_idx;
    logic [7:0] a_idx;
    logic [6:0] bits;
    folded = (code >= CODE_LOWER_LO && code <= CODE_LOWER_HI) ? code - CASE_FOLD : code;
    d_idx  = code - CODE_DIGIT_LO;
    a_idx  = folded - CODE_UPPER_LO;
    bits   = '0;
    if (col < GLYPH_COLS) begin
      if (code >= CODE_DIGIT_LO && code <= CODE_DIGIT_HI) begin
        bits = DIGIT_FONT[d_idx[3:0]][col];
      end else if (folded >= CODE_UPPER_LO && folded <= CODE_UPPER_HI) begin
        bits = ALPHA_FONT[a_idx[4:0]][col];
      end else if (code == CODE_DASH && col == MARK_COL) begin
        bits = DASH_BITS;
      end else if (code == CODE_DOT && col == MARK_COL) begin
        bits = DOT_BITS;
      end
    end
    return bits;
  endfunction

endpackage

// ===== hw/rtl/gtr_if.sv =====
// ----------------------------------------------------------------------------
// gtr_if: valid/ready channels of the glyph text rasterizer
// Character channel in, pixel write channel out.
// ----------------------------------------------------------------------------
interface gtr_char_if;
  logic               valid;
  logic               ready;
  logic               new_string;
  logic signed [15:0] start_x;
  logic signed [15:0] start_y;
  logic [7:0]         character;
  logic [15:0]        ink_color;

  modport source (output valid, new_string, start_x, start_y, character, ink_color,
                  input ready);
  modport sink (input valid, new_string, start_x, start_y, character, ink_color,
                output ready);
endinterface

interface gtr_pix_if;
  logic        valid;
  logic        ready;
  logic        write_enable;
  logic [31:0] write_address;
  logic [15:0] pixel_color;
  logic        last;

  modport source (output valid, write_enable, write_address, pixel_color, last,
                  input ready);
  modport sink (input valid, write_enable, write_address, pixel_color, last,
                output ready);
endinterface

// ===== hw/rtl/glyph_text_rasterizer.sv =====
// ----------------------------------------------------------------------------
// glyph_text_rasterizer: 5x7 font character generator
// Turns one character transaction into 35 framebuffer pixel write transactions.
// ----------------------------------------------------------------------------
//
//  channel   dir  transaction
//  --------  ---  ------------------------------------------------------------
//  chars     in   new_string, start_x, start_y, character, ink_color
//  pixels    out  write_enable, write_address, pixel_color, last
//  cfg_wr_*  in   frame_base, written when cfg_wr_en is high
//
//  the column/row counter issues one pixel per cycle while pixels does not stall
//  the next character is taken in the cycle that issues the last pixel, so a
//  steady stream of characters runs with no gap between them
//  the pixel output register takes a new pixel whenever it is empty or being taken
//  a stall on pixels freezes the counter; chars stays low until the last pixel issues
//  rst (synchronous) clears the pen, frame_base and all valid/busy flags
//
module glyph_text_rasterizer #(
  parameter int DISPLAY_WIDTH  = 480,
  parameter int DISPLAY_HEIGHT = 272,
  parameter int LINE_STRIDE    = 480
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data,
  gtr_char_if.sink    chars,
  gtr_pix_if.source   pixels
);
  import gtr_pkg::*;

  // index widths on screen
  localparam int X_W   = $clog2(DISPLAY_WIDTH);
  localparam int Y_W   = $clog2(DISPLAY_HEIGHT);
  localparam int S_W   = $clog2(LINE_STRIDE + 1);
  localparam int YS_W  = Y_W + S_W;
  localparam int OFF_W = ((YS_W > X_W) ? YS_W : X_W) + 1;

  localparam logic signed [17:0] WIDTH_S  = 18'(DISPLAY_WIDTH);
  localparam logic signed [16:0] HEIGHT_S = 17'(DISPLAY_HEIGHT);
  localparam logic [OFF_W-1:0]   STRIDE_V = OFF_W'(LINE_STRIDE);

  // configuration and pen state
  logic [31:0]        frame_base;
  logic signed [16:0] pen_x;
  logic signed [15:0] pen_y;

  // character being drawn
  logic               busy;
  logic [2:0]         col;
  logic [2:0]         row;
  logic signed [16:0] cur_x;
  logic signed [15:0] cur_y;
  logic [7:0]         cur_code;
  logic [15:0]        cur_ink;
  logic               started_on;

  // pixel output register
  logic        out_valid;
  logic        out_we;
  logic [31:0] out_addr;
  logic [15:0] out_color;
  logic        out_last;

  logic               out_load;
  logic               step;
  logic               at_end;
  logic               item_done;
  logic               accept;
  logic signed [16:0] base_x;
  logic signed [15:0] base_y;
  logic signed [17:0] adv_x;
  logic signed [16:0] pen_x_next;

  logic [6:0]         bits;
  logic signed [17:0] px;
  logic signed [16:0] py;
  logic               on_screen;
  logic               we_next;
  logic [OFF_W-1:0]   offset;
  logic [31:0]        addr_next;

  // handshake and sequencing
  assign out_load  = !out_valid || pixels.ready;
  assign step      = busy && out_load;
  assign at_end    = (col == LAST_COL) && (row == LAST_ROW);
  assign item_done = step && at_end;
  assign chars.ready = !busy || item_done;
  assign accept    = chars.valid && chars.ready;

  // pen position for the incoming character, then the saturating advance
  assign base_x = chars.new_string ? 17'(chars.start_x) : pen_x;
  assign base_y = chars.new_string ? chars.start_y : pen_y;
  assign adv_x  = 18'(base_x) + PEN_ADVANCE;
  assign pen_x_next = (adv_x > PEN_X_MAX) ? PEN_X_MAX[16:0] : adv_x[16:0];

  // one pixel of the glyph per cycle, unless pixels stalls
  always_comb begin
    bits      = font_column(cur_code, col);
    px        = 18'(cur_x) + $signed({15'd0, col});
    py        = 17'(cur_y) + $signed({14'd0, row});
    on_screen = !px[17] && !py[16] && (px < WIDTH_S) && (py < HEIGHT_S);
    we_next   = started_on && bits[row] && on_screen;
    offset    = OFF_W'(py[Y_W-1:0]) * STRIDE_V + OFF_W'(px[X_W-1:0]);
    addr_next = we_next ? frame_base + 32'({offset, 1'b0}) : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_base <= '0;
    end else if (cfg_wr_en) begin
      frame_base <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pen_x <= '0;
      pen_y <= '0;
      busy  <= 1'b0;
      col   <= '0;
      row   <= '0;
    end else begin
      // a new character may start in the same cycle the old one ends
      if (accept) begin
        busy  <= 1'b1;
        col   <= '0;
        row   <= '0;
        pen_x <= pen_x_next;
        pen_y <= base_y;
      end else begin
        if (item_done) begin
          busy <= 1'b0;
        end
        if (step) begin
          if (row == LAST_ROW) begin
            row <= '0;
            col <= col + 3'd1;
          end else begin
            row <= row + 3'd1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cur_x      <= base_x;
      cur_y      <= base_y;
      cur_code   <= chars.character;
      cur_ink    <= chars.ink_color;
      started_on <= 18'(base_x) < WIDTH_S;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= step;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_we    <= we_next;
      out_addr  <= addr_next;
      out_color <= cur_ink;
      out_last  <= at_end;
    end
  end

  assign pixels.valid         = out_valid;
  assign pixels.write_enable  = out_we;
  assign pixels.write_address = out_addr;
  assign pixels.pixel_color   = out_color;
  assign pixels.last          = out_last;

`ifndef SYNTH
  // a started character always begins at its first pixel
  a_start_at_origin: assert property (@(posedge clk) disable iff (rst)
    accept |=> busy && col == '0 && row == '0)
    else $error("character did not start at column 0 row 0");

  // no new character while pixels of the current one remain
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    busy && !item_done |-> !chars.ready)
    else $error("character accepted before last pixel issued");

  // suppressed pixels carry a zero address
  a_idle_addr: assert property (@(posedge clk) disable iff (rst)
    pixels.valid && !pixels.write_enable |-> pixels.write_address == '0)
    else $error("unwritten pixel with nonzero address");

  // the counter never leaves the glyph
  a_counter_range: assert property (@(posedge clk) disable iff (rst)
    busy |-> col < GLYPH_COLS && row < GLYPH_ROWS)
    else $error("pixel counter out of glyph");
`endif

endmodule
